[hw/rtl/soft_sphere_mask_voxel_assert.svh]
// Assertion macros used by the port-level checker of the soft sphere mask block.
// Needs nothing but the clock and reset names handed in by the caller.
`ifndef SOFT_SPHERE_MASK_VOXEL_ASSERT_SVH
`define SOFT_SPHERE_MASK_VOXEL_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define SSM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssm check failed");

// Next-cycle implication, disabled while rst is high.
`define SSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssm check failed");

`endif

[hw/rtl/ssm_pkg.sv]
// Shared types and constants of the soft sphere mask voxel block.
// Used by the top level and the square-root pipeline; no dependencies.
`default_nettype none

package ssm_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int MAX_SIZE          = 256;

   localparam int INDEX_W  = 8;
   localparam int ADDR_W   = 24;
   localparam int SIZE_W   = 9;
   localparam int RADIUS_W = 17;
   localparam int CENTER_W = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] REG_VOLUME_SIZE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_ROW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_COL   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_SLICE = 3'd4;

   localparam logic [SIZE_W-1:0] VOLUME_SIZE_RESET = 9'd64;

   // Per-voxel results that ride alongside the distance computation.
   typedef struct packed {
      logic [ADDR_W-1:0] voxel_address;
      logic              outside_volume;
   } side_type;

endpackage

`default_nettype wire

[hw/rtl/ssm_isqrt.sv]
// Pipelined floor square root, one result bit per stage, with sideband.
// Depends on ssm_pkg for the sideband type.
`default_nettype none

module ssm_isqrt #(
   parameter int SUM_W = 34
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [SUM_W-1:0]       in_radicand,
   input  wire ssm_pkg::side_type      in_side,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [SUM_W/2-1:0]          out_root,
   output ssm_pkg::side_type           out_side
);

   localparam int STEPS  = SUM_W / 2;
   localparam int ROOT_W = SUM_W / 2;

   logic                 valid_ff [STEPS];
   logic [SUM_W-1:0]     res_ff   [STEPS];
   logic [SUM_W-1:0]     v_ff     [STEPS-1];
   ssm_pkg::side_type    side_ff  [STEPS];
   logic                 rdy      [STEPS+1];

   assign rdy[STEPS] = out_ready;
   assign in_ready   = rdy[0];

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      localparam logic [SUM_W-1:0] BIT_VAL = SUM_W'(1) << (2 * (STEPS - 1 - k));

      logic                 src_valid;
      logic [SUM_W-1:0]     src_v;
      logic [SUM_W-1:0]     src_res;
      ssm_pkg::side_type    src_side;
      logic [SUM_W:0]       trial;
      logic                 take;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_v     = in_radicand;
         assign src_res   = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_v     = v_ff[k-1];
         assign src_res   = res_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      assign rdy[k] = !valid_ff[k] || rdy[k+1];
      assign trial  = {1'b0, src_res} + {1'b0, BIT_VAL};
      assign take   = {1'b0, src_v} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            side_ff[k] <= src_side;
            if (take) begin
               res_ff[k] <= (src_res >> 1) + BIT_VAL;
            end else begin
               res_ff[k] <= src_res >> 1;
            end
         end
      end

      // The last stage needs only the root, not the remainder.
      if (k < STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               if (take) begin
                  v_ff[k] <= src_v - trial[SUM_W-1:0];
               end else begin
                  v_ff[k] <= src_v;
               end
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = res_ff[STEPS-1][ROOT_W-1:0];
   assign out_side  = side_ff[STEPS-1];

endmodule

`default_nettype wire

[hw/rtl/soft_sphere_mask_voxel.sv]
// Soft-edged spherical mask per voxel, with linear address and bounds flag.
// Depends on ssm_pkg and ssm_isqrt.
//
//   Channel  Dir  Beat contents
//   req_     in   row_index, col_index, slice_index
//   rsp_     out  mask_value, voxel_address, outside_volume
//   csr_     in   register write: index, data (no read-back)
//
// One voxel per cycle sustained while rsp_tready stays high; the square-root
// pipeline resolves one root bit per stage after three stages of difference,
// square and sum, and a registered output stage follows it.
// Synchronous reset clears every valid bit and loads the register reset values.
// Every stage holds its beat only while the stage after it is full and stalled;
// empty stages fill, so bubbles close up behind a stalled output.
`default_nettype none

module soft_sphere_mask_voxel #(
   parameter int FRAC_BITS = ssm_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   // req_tdata: row_index[7:0], col_index[15:8], slice_index[23:16]
   input  wire logic                                        req_tvalid,
   output logic                                             req_tready,
   input  wire logic [3*ssm_pkg::INDEX_W-1:0]               req_tdata,
   // rsp_tdata: mask_value, voxel_address, outside_volume, zero fill
   output logic                                             rsp_tvalid,
   input  wire logic                                        rsp_tready,
   output logic [((FRAC_BITS+1+ssm_pkg::ADDR_W+1+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                                        csr_we,
   input  wire logic [ssm_pkg::CSR_INDEX_W-1:0]             csr_index,
   input  wire logic [ssm_pkg::CSR_DATA_W-1:0]              csr_wdata
);

   localparam int IW      = ssm_pkg::INDEX_W;
   localparam int AW      = ssm_pkg::ADDR_W;
   localparam int LW      = ssm_pkg::SIZE_W;
   localparam int RW      = ssm_pkg::RADIUS_W;
   localparam int CW      = ssm_pkg::CENTER_W;
   localparam int POS_W   = IW + FRAC_BITS;
   localparam int DIFF_W  = (POS_W > CW) ? POS_W : CW;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int CMP_W   = ((ROOT_W > RW) ? ROOT_W : RW) + 1;
   localparam int MASK_W  = FRAC_BITS + 1;
   localparam int RSP_W   = ((MASK_W + AW + 1 + 7) / 8) * 8;
   localparam int RL_W    = IW + LW;
   localparam int RLL_W   = RL_W + LW;

   localparam logic [MASK_W-1:0] MASK_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // Configuration registers
   logic [LW-1:0] volume_size_ff;
   logic [RW-1:0] radius_ff;
   logic [CW-1:0] center_row_ff;
   logic [CW-1:0] center_col_ff;
   logic [CW-1:0] center_slice_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_size_ff  <= ssm_pkg::VOLUME_SIZE_RESET;
         radius_ff       <= '0;
         center_row_ff   <= '0;
         center_col_ff   <= '0;
         center_slice_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ssm_pkg::REG_VOLUME_SIZE:  volume_size_ff  <= csr_wdata[LW-1:0];
            ssm_pkg::REG_RADIUS:       radius_ff       <= csr_wdata[RW-1:0];
            ssm_pkg::REG_CENTER_ROW:   center_row_ff   <= csr_wdata[CW-1:0];
            ssm_pkg::REG_CENTER_COL:   center_col_ff   <= csr_wdata[CW-1:0];
            ssm_pkg::REG_CENTER_SLICE: center_slice_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [DIFF_W-1:0] abs_diff(input logic [IW-1:0] idx,
                                                  input logic [CW-1:0] ctr);
      logic [DIFF_W:0] pos;
      logic [DIFF_W:0] cen;
      pos = (DIFF_W+1)'({idx, {FRAC_BITS{1'b0}}});
      cen = (DIFF_W+1)'(ctr);
      if (pos >= cen) begin
         return DIFF_W'(pos - cen);
      end
      return DIFF_W'(cen - pos);
   endfunction

   logic [IW-1:0] req_row;
   logic [IW-1:0] req_col;
   logic [IW-1:0] req_slice;
   logic [LW-1:0] len;

   assign req_row   = req_tdata[IW-1:0];
   assign req_col   = req_tdata[2*IW-1:IW];
   assign req_slice = req_tdata[3*IW-1:2*IW];

   // Saturate the edge length at the largest supported volume.
   assign len = (32'(volume_size_ff) > ssm_pkg::MAX_SIZE) ?
                LW'(ssm_pkg::MAX_SIZE) : volume_size_ff;

   // Stage 1: axis differences, first address products, bounds flag
   logic              s1_valid_ff;
   logic [DIFF_W-1:0] s1_diff_row_ff;
   logic [DIFF_W-1:0] s1_diff_col_ff;
   logic [DIFF_W-1:0] s1_diff_slice_ff;
   logic [RL_W-1:0]   s1_row_len_ff;
   logic [RL_W-1:0]   s1_slice_len_ff;
   logic [IW-1:0]     s1_col_ff;
   logic [LW-1:0]     s1_len_ff;
   logic              s1_outside_ff;
   logic              s1_ready;

   // Stage 2: squares, partial address
   logic              s2_valid_ff;
   logic [SQ_W-1:0]   s2_sq_row_ff;
   logic [SQ_W-1:0]   s2_sq_col_ff;
   logic [SQ_W-1:0]   s2_sq_slice_ff;
   logic [RL_W:0]     s2_addr_lo_ff;
   logic [AW-1:0]     s2_slice_area_ff;
   logic              s2_outside_ff;
   logic              s2_ready;
   logic [RLL_W-1:0]  slice_area;

   // Stage 3: sum of squares, full address
   logic              s3_valid_ff;
   logic [SUM_W-1:0]  s3_sum_ff;
   ssm_pkg::side_type s3_side_ff;
   logic              s3_ready;

   // Square root
   logic              sq_in_ready;
   logic              sq_out_valid;
   logic [ROOT_W-1:0] sq_root;
   ssm_pkg::side_type sq_side;

   // Output stage
   logic              rsp_valid_ff;
   logic [MASK_W-1:0] rsp_mask_ff;
   ssm_pkg::side_type rsp_side_ff;
   logic              rsp_ready;
   logic [CMP_W-1:0]  rad_ext;
   logic [CMP_W-1:0]  dist_ext;
   logic [CMP_W-1:0]  mask_diff;
   logic [MASK_W-1:0] mask_in;

   assign rsp_ready  = !rsp_valid_ff || rsp_tready;
   assign s3_ready   = !s3_valid_ff || sq_in_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_diff_row_ff   <= abs_diff(req_row, center_row_ff);
         s1_diff_col_ff   <= abs_diff(req_col, center_col_ff);
         s1_diff_slice_ff <= abs_diff(req_slice, center_slice_ff);
         s1_row_len_ff    <= req_row * len;
         s1_slice_len_ff  <= req_slice * len;
         s1_col_ff        <= req_col;
         s1_len_ff        <= len;
         s1_outside_ff    <= (LW'(req_row) >= len) || (LW'(req_col) >= len) ||
                             (LW'(req_slice) >= len);
      end
   end

   assign slice_area = s1_slice_len_ff * s1_len_ff;

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_sq_row_ff     <= s1_diff_row_ff * s1_diff_row_ff;
         s2_sq_col_ff     <= s1_diff_col_ff * s1_diff_col_ff;
         s2_sq_slice_ff   <= s1_diff_slice_ff * s1_diff_slice_ff;
         s2_addr_lo_ff    <= (RL_W+1)'(s1_col_ff) + (RL_W+1)'(s1_row_len_ff);
         s2_slice_area_ff <= slice_area[AW-1:0];
         s2_outside_ff    <= s1_outside_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_sum_ff <= SUM_W'(s2_sq_row_ff) + SUM_W'(s2_sq_col_ff) +
                      SUM_W'(s2_sq_slice_ff);
         s3_side_ff.voxel_address  <= AW'(s2_addr_lo_ff) + s2_slice_area_ff;
         s3_side_ff.outside_volume <= s2_outside_ff;
      end
   end

   ssm_isqrt #(
      .SUM_W (SUM_W)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s3_valid_ff),
      .in_ready    (sq_in_ready),
      .in_radicand (s3_sum_ff),
      .in_side     (s3_side_ff),
      .out_valid   (sq_out_valid),
      .out_ready   (rsp_ready),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // Clamp radius minus distance to the range zero to one.
   always_comb begin
      rad_ext   = CMP_W'(radius_ff);
      dist_ext  = CMP_W'(sq_root);
      mask_diff = rad_ext - dist_ext;
      priority if (rad_ext <= dist_ext) begin
         mask_in = '0;
      end else if (mask_diff > CMP_W'(MASK_ONE)) begin
         mask_in = MASK_ONE;
      end else begin
         mask_in = MASK_W'(mask_diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= sq_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready) begin
         rsp_mask_ff <= mask_in;
         rsp_side_ff <= sq_side;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_side_ff.outside_volume, rsp_side_ff.voxel_address,
                               rsp_mask_ff});

endmodule

`default_nettype wire

[hw/rtl/ssm_checker.sv]
// Port-level checks for soft_sphere_mask_voxel, attached by bind.
// Depends on soft_sphere_mask_voxel_assert.svh and ssm_pkg.
`default_nettype none

`include "soft_sphere_mask_voxel_assert.svh"

module ssm_checker #(
   parameter int FRAC_BITS = ssm_pkg::FRAC_BITS_DEFAULT
) (
   input wire logic                                        clock,
   input wire logic                                        reset,
   input wire logic                                        rsp_tvalid,
   input wire logic                                        rsp_tready,
   input wire logic [((FRAC_BITS+1+ssm_pkg::ADDR_W+1+7)/8)*8-1:0] rsp_tdata
);

   localparam int MASK_W = FRAC_BITS + 1;
   localparam logic [MASK_W-1:0] MASK_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // a stalled result beat stays offered and unchanged
   `SSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `SSM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // no result beat may come out of a pipeline that reset just emptied
   `SSM_ASSERT_NOW(a_reset_empty, clock, 1'b0, $past(reset), !rsp_tvalid)

   // the clamp never lets the mask exceed one
   `SSM_ASSERT_NOW(a_mask_range, clock, reset, rsp_tvalid, rsp_tdata[MASK_W-1:0] <= MASK_ONE)

endmodule

bind soft_sphere_mask_voxel ssm_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_ssm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[tb/soft_sphere_mask_voxel_checker.sv]
// Scoreboard for the soft sphere mask voxel block: tracks register writes,
// predicts mask, address and bounds flag per voxel beat, compares rsp beats.
// Depends on ssm_pkg for widths and register indexes.
module soft_sphere_mask_voxel_checker
   import ssm_pkg::*;
#(
   parameter int MASK_W = FRAC_BITS_DEFAULT + 1,
   parameter int RSP_W  = ((MASK_W + ADDR_W + 1 + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // req_tdata: row_index, col_index, slice_index
   input  wire logic [3*INDEX_W-1:0]   req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // rsp_tdata: mask_value, voxel_address, outside_volume, zero fill
   input  wire logic [RSP_W-1:0]       rsp_tdata,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          mismatch_count,
   output int                          pending_count
);

   localparam int ADDR_LSB = MASK_W;
   localparam int OUT_BIT  = MASK_W + ADDR_W;
   localparam longint unsigned UNITY = 64'd1 << FRAC_BITS_DEFAULT;

   typedef struct packed {
      logic [MASK_W-1:0] mask_value;
      logic [ADDR_W-1:0] voxel_address;
      logic              outside_volume;
   } voxel_result_type;

   voxel_result_type results_due[$];

   logic [SIZE_W-1:0]   volume_size;
   logic [RADIUS_W-1:0] radius_q8;
   logic [CENTER_W-1:0] center_row_q8;
   logic [CENTER_W-1:0] center_col_q8;
   logic [CENTER_W-1:0] center_slice_q8;

   // Largest root whose square does not exceed v; v stays below 2^34.
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 17; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v)
            root = trial;
      end
      return root;
   endfunction

   function automatic longint unsigned axis_offset_sq(input logic [INDEX_W-1:0] idx,
                                                      input logic [CENTER_W-1:0] centre);
      longint unsigned pos;
      longint unsigned d;
      pos = 64'(idx) << FRAC_BITS_DEFAULT;
      d = (pos >= 64'(centre)) ? pos - 64'(centre) : 64'(centre) - pos;
      return d * d;
   endfunction

   function automatic voxel_result_type predict_voxel(input logic [3*INDEX_W-1:0] beat);
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic [INDEX_W-1:0] slc;
      longint unsigned    len;
      longint unsigned    distance;
      longint unsigned    margin;
      voxel_result_type   res;
      row = beat[INDEX_W-1:0];
      col = beat[2*INDEX_W-1:INDEX_W];
      slc = beat[3*INDEX_W-1:2*INDEX_W];
      // saturate oversized edge length
      len = (volume_size > SIZE_W'(MAX_SIZE)) ? 64'(MAX_SIZE) : 64'(volume_size);
      distance = floor_root(axis_offset_sq(row, center_row_q8)
                          + axis_offset_sq(col, center_col_q8)
                          + axis_offset_sq(slc, center_slice_q8));
      if (64'(radius_q8) <= distance) begin
         res.mask_value = '0;
      end else begin
         margin = 64'(radius_q8) - distance;
         res.mask_value = (margin > UNITY) ? MASK_W'(UNITY) : MASK_W'(margin);
      end
      res.voxel_address = ADDR_W'(64'(col) + 64'(row) * len + 64'(slc) * len * len);
      res.outside_volume = (64'(row) >= len) || (64'(col) >= len) || (64'(slc) >= len);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      voxel_result_type want;
      if (reset) begin
         results_due.delete();
         volume_size     = VOLUME_SIZE_RESET;
         radius_q8       = '0;
         center_row_q8   = '0;
         center_col_q8   = '0;
         center_slice_q8 = '0;
         mismatch_count  = 0;
         pending_count  <= 0;
      end else begin
         // retire before enqueue: a beat accepted now cannot be answered now
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $error("rsp beat with no voxel outstanding: tdata %h", rsp_tdata);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata[MASK_W-1:0] !== want.mask_value) begin
                  $error("mask_value: expected %0d, got %0d",
                         want.mask_value, rsp_tdata[MASK_W-1:0]);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_tdata[ADDR_LSB +: ADDR_W] !== want.voxel_address) begin
                  $error("voxel_address: expected %0d, got %0d",
                         want.voxel_address, rsp_tdata[ADDR_LSB +: ADDR_W]);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_tdata[OUT_BIT] !== want.outside_volume) begin
                  $error("outside_volume: expected %0d, got %0d",
                         want.outside_volume, rsp_tdata[OUT_BIT]);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            results_due.push_back(predict_voxel(req_tdata));
         if (csr_we) begin
            case (csr_index)
               REG_VOLUME_SIZE:  volume_size     = csr_wdata[SIZE_W-1:0];
               REG_RADIUS:       radius_q8       = csr_wdata[RADIUS_W-1:0];
               REG_CENTER_ROW:   center_row_q8   = csr_wdata[CENTER_W-1:0];
               REG_CENTER_COL:   center_col_q8   = csr_wdata[CENTER_W-1:0];
               REG_CENTER_SLICE: center_slice_q8 = csr_wdata[CENTER_W-1:0];
               default: ;
            endcase
         end
         pending_count <= results_due.size();
      end
   end

endmodule

[tb/tb_soft_sphere_mask_voxel.sv]
// Top of the soft sphere mask voxel testbench: clock, reset, register setups,
// voxel beats and rsp back-pressure; the checker module does all comparing.
// Depends on ssm_pkg, soft_sphere_mask_voxel and soft_sphere_mask_voxel_checker.
module tb_soft_sphere_mask_voxel;
   import ssm_pkg::*;

   localparam int MASK_W      = FRAC_BITS_DEFAULT + 1;
   localparam int RSP_W       = ((MASK_W + ADDR_W + 1 + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LATENCY     = 21;
   localparam int PHASES      = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_FIRST = REG_CENTER_SLICE + 3'd1;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [3*INDEX_W-1:0]   req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int mismatch_count;
   int pending_count;
   int cycle_count    = 0;
   bit want_long_hold = 1'b0;

   // sphere of the current setup, used to aim voxels at the soft edge
   logic [RADIUS_W-1:0] aim_radius = '0;
   logic [CENTER_W-1:0] aim_row    = '0;
   logic [CENTER_W-1:0] aim_col    = '0;
   logic [CENTER_W-1:0] aim_slice  = '0;

   always #4 clock = ~clock;

   soft_sphere_mask_voxel DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   soft_sphere_mask_voxel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // rsp side: windows of differing stall patterns, one long hold on request
   initial begin : rsp_pacing
      int mode;
      int span;
      bit held;
      held = 1'b0;
      forever begin
         if (want_long_hold && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(8, 96);
            for (int k = 0; k < span; k++) begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= (k % 4 == 0);
                  3: rsp_tready <= ($urandom_range(0, 9) != 0);
                  default: rsp_tready <= ($urandom_range(0, 7) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Offer one voxel and hold it until accepted; valid stays high afterwards.
   task automatic send_voxel(input logic [INDEX_W-1:0] row, input logic [INDEX_W-1:0] col,
                             input logic [INDEX_W-1:0] slc);
      req_tvalid <= 1'b1;
      req_tdata  <= {slc, col, row};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write every register, then one unmapped index that must be dropped.
   task automatic load_setup(input logic [CSR_DATA_W-1:0] size,
                             input logic [CSR_DATA_W-1:0] radius,
                             input logic [CSR_DATA_W-1:0] c_row,
                             input logic [CSR_DATA_W-1:0] c_col,
                             input logic [CSR_DATA_W-1:0] c_slice);
      set_reg(REG_VOLUME_SIZE, size);
      set_reg(REG_RADIUS, radius);
      set_reg(REG_CENTER_ROW, c_row);
      set_reg(REG_CENTER_COL, c_col);
      set_reg(REG_CENTER_SLICE, c_slice);
      set_reg(CSR_INDEX_W'(REG_UNMAPPED_FIRST + $urandom_range(0, 2)),
              CSR_DATA_W'($urandom));
      csr_we     <= 1'b0;
      aim_radius  = radius[RADIUS_W-1:0];
      aim_row     = c_row[CENTER_W-1:0];
      aim_col     = c_col[CENTER_W-1:0];
      aim_slice   = c_slice[CENTER_W-1:0];
   endtask

   task automatic load_random_setup();
      logic [CSR_DATA_W-1:0] size;
      logic [CSR_DATA_W-1:0] radius;
      case ($urandom_range(0, 7))
         0: size = CSR_DATA_W'(0);
         1: size = CSR_DATA_W'(1);
         2: size = CSR_DATA_W'(MAX_SIZE);
         3: size = CSR_DATA_W'($urandom_range(MAX_SIZE + 1, 511));
         4: size = CSR_DATA_W'($urandom);
         default: size = CSR_DATA_W'($urandom_range(2, MAX_SIZE - 1));
      endcase
      case ($urandom_range(0, 7))
         0: radius = '0;
         1: radius = '1;
         2, 3: radius = CSR_DATA_W'($urandom);
         default: radius = CSR_DATA_W'($urandom_range(0, 4095));
      endcase
      load_setup(size, radius, CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                 CSR_DATA_W'($urandom));
   endtask

   // Index at most the radius plus two voxels from the given centre coordinate, clipped to 0..255.
   function automatic logic [INDEX_W-1:0] near_shell(input logic [CENTER_W-1:0] centre);
      int reach;
      int pos;
      reach = int'(aim_radius >> FRAC_BITS_DEFAULT) + 2;
      if (reach > 255)
         reach = 255;
      pos = int'(centre >> FRAC_BITS_DEFAULT) + int'($urandom_range(0, 2 * reach)) - reach;
      if (pos < 0)
         pos = 0;
      else if (pos > 255)
         pos = 255;
      return INDEX_W'(pos);
   endfunction

   task automatic stream_voxels(input int beats, input bit with_gaps);
      int burst;
      logic [INDEX_W-1:0] r;
      logic [INDEX_W-1:0] c;
      logic [INDEX_W-1:0] s;
      burst = $urandom_range(1, 24);
      for (int n = 0; n < beats; n++) begin
         if ($urandom_range(0, 9) < 6) begin
            r = near_shell(aim_row);
            c = near_shell(aim_col);
            s = near_shell(aim_slice);
         end else begin
            r = INDEX_W'($urandom);
            c = INDEX_W'($urandom);
            s = INDEX_W'($urandom);
         end
         send_voxel(r, c, s);
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            if (with_gaps) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset values: zero radius, edge 64
      send_voxel(8'd0, 8'd0, 8'd0);
      send_voxel(8'd255, 8'd255, 8'd255);
      send_voxel(8'd63, 8'd63, 8'd63);
      send_voxel(8'd64, 8'd0, 8'd0);
      drain_results();

      // full volume, sphere of 64.39 voxels at the middle: clamp, soft edge, zero
      load_setup(17'd256, 17'd16484, 17'd32768, 17'd32768, 17'd32768);
      send_voxel(8'd128, 8'd128, 8'd128);
      send_voxel(8'd128, 8'd128, 8'd191);
      send_voxel(8'd128, 8'd128, 8'd192);
      send_voxel(8'd129, 8'd129, 8'd192);
      send_voxel(8'd0, 8'd0, 8'd0);
      send_voxel(8'd255, 8'd255, 8'd255);
      drain_results();

      // zero edge length, largest radius, centre at the extremes
      load_setup(17'd0, 17'd131071, 17'd65535, 17'd0, 17'd65535);
      send_voxel(8'd0, 8'd0, 8'd0);
      send_voxel(8'd255, 8'd0, 8'd255);
      send_voxel(8'd0, 8'd255, 8'd0);
      drain_results();

      // edge length beyond the maximum saturates
      load_setup(17'd511, 17'd300, 17'd100, 17'd200, 17'd300);
      send_voxel(8'd255, 8'd255, 8'd255);
      send_voxel(8'd0, 8'd1, 8'd2);
      drain_results();

      // single-voxel volume
      load_setup(17'd1, 17'd256, 17'd0, 17'd0, 17'd0);
      send_voxel(8'd0, 8'd0, 8'd0);
      send_voxel(8'd0, 8'd0, 8'd1);
      send_voxel(8'd1, 8'd0, 8'd0);
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         // fill the pipe against a long rsp hold in one phase
         if (p == 3)
            want_long_hold = 1'b1;
         load_random_setup();
         stream_voxels((p == 3) ? 400 : 170, (p != 3) && (p % 4 != 1));
         drain_results();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[soft_sphere_mask_voxel.f]
+incdir+hw/rtl
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_isqrt.sv
hw/rtl/soft_sphere_mask_voxel.sv
hw/rtl/ssm_checker.sv
tb/soft_sphere_mask_voxel_checker.sv
tb/tb_soft_sphere_mask_voxel.sv
